@@ hw/rtl/icmp_echo_reply_checker_defines.svh @@
// ============================================================================
// icmp_echo_reply_checker_defines.svh
// Assertion macros shared by the echo reply checker RTL.
// ============================================================================
`ifndef ICMP_ECHO_REPLY_CHECKER_DEFINES_SVH
`define ICMP_ECHO_REPLY_CHECKER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ERC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ERC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/icmp_erc_pkg.sv @@
// ============================================================================
// icmp_erc_pkg
// Types, constants and helpers of the ICMP echo reply checker.
// ============================================================================
`timescale 1ns / 1ps

package icmp_erc_pkg;

    localparam int MAX_PACKET_BYTES = 2048;
    localparam int POS_W            = $clog2(MAX_PACKET_BYTES + 1);
    localparam int PLEN_W           = 11;
    localparam int WORD_W           = 16;
    localparam int SUM_W            = WORD_W + 1;

    localparam logic [WORD_W-1:0] WORD_MASK       = 16'hffff;
    localparam logic [PLEN_W-1:0] PAYLOAD_LEN_RST = 11'd56;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_EXPECTED_ID = 1'b0,
        CFG_PAYLOAD_LEN = 1'b1
    } t_cfg_index;

    // IP header byte offsets and values
    localparam logic [POS_W-1:0] IP_OFS_TTL   = 12'd8;
    localparam logic [POS_W-1:0] IP_OFS_PROTO = 12'd9;
    localparam logic [7:0]       PROTO_ICMP   = 8'd1;

    // ICMP header byte offsets and values
    localparam logic [POS_W-1:0] ICMP_OFS_TYPE  = 12'd0;
    localparam logic [POS_W-1:0] ICMP_OFS_CK_HI = 12'd2;
    localparam logic [POS_W-1:0] ICMP_OFS_CK_LO = 12'd3;
    localparam logic [POS_W-1:0] ICMP_OFS_ID_HI = 12'd4;
    localparam logic [POS_W-1:0] ICMP_OFS_ID_LO = 12'd5;
    localparam logic [POS_W-1:0] ICMP_OFS_SQ_HI = 12'd6;
    localparam logic [POS_W-1:0] ICMP_OFS_SQ_LO = 12'd7;
    localparam logic [POS_W-1:0] ICMP_HDR_BYTES = 12'd8;
    localparam logic [7:0]       ICMP_ECHO_REPLY = 8'd0;

    localparam int FIFO_DEPTH = 2;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // per-packet summary handed from front to back
    typedef struct packed {
        logic [POS_W-1:0]  byte_count;
        logic [5:0]        hdr_bytes;
        logic              is_icmp;
        logic [7:0]        ttl;
        logic [7:0]        msg_type;
        logic [WORD_W-1:0] ident;
        logic [WORD_W-1:0] seq;
        logic [WORD_W-1:0] rx_cksum;
        logic [SUM_W-1:0]  sum;
        logic [7:0]        high_byte;
        logic [POS_W-1:0]  limit;
    } t_pkt_rec;

    // result fields, packed into m_axis_tdata by the top level
    typedef struct packed {
        logic              ck_mismatch;
        logic [WORD_W-1:0] received_cksum;
        logic [WORD_W-1:0] computed_cksum;
        logic              type_valid;
        logic [7:0]        msg_type;
        logic [7:0]        ttl;
        logic [WORD_W-1:0] sequence_res;
        logic [11:0]       icmp_bytes;
    } t_result;

    // ones-complement add with end-around carry; bit 16 of acc is dropped
    function automatic logic [SUM_W-1:0] fold_add(input logic [SUM_W-1:0]  acc,
                                                   input logic [WORD_W-1:0] word);
        logic [SUM_W-1:0] s;
        s = {1'b0, acc[WORD_W-1:0] & WORD_MASK} + {1'b0, word & WORD_MASK};
        return {1'b0, s[WORD_W-1:0]} + SUM_W'(s[WORD_W]);
    endfunction

endpackage

@@ hw/rtl/icmp_erc_front.sv @@
// ============================================================================
// icmp_erc_front
// Byte parser: captures header fields, accumulates the ICMP checksum and
// emits one packet summary at the last byte.
// ============================================================================
`timescale 1ns / 1ps
`include "icmp_echo_reply_checker_defines.svh"

module icmp_erc_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_accept,
    input  logic [7:0]                      i_data_byte,
    input  logic                            i_last,
    input  logic [icmp_erc_pkg::PLEN_W-1:0] i_payload_len,
    output logic                            o_push,
    output icmp_erc_pkg::t_pkt_rec          o_rec
);
    import icmp_erc_pkg::*;

    logic [POS_W-1:0]  r_pos,    n_pos;
    logic [3:0]        r_hw,     n_hw;
    logic              r_icmp,   n_icmp;
    logic [7:0]        r_ttl,    n_ttl;
    logic [7:0]        r_type,   n_type;
    logic [WORD_W-1:0] r_id,     n_id;
    logic [WORD_W-1:0] r_seq,    n_seq;
    logic [WORD_W-1:0] r_rxck,   n_rxck;
    logic [SUM_W-1:0]  r_sum,    n_sum;
    logic [7:0]        r_hbh,    n_hbh;

    logic [5:0]        hl;
    logic [POS_W-1:0]  rel;
    logic [POS_W-1:0]  limit;
    logic [7:0]        v;

    always_comb begin
        n_pos  = r_pos;
        n_hw   = r_hw;
        n_icmp = r_icmp;
        n_ttl  = r_ttl;
        n_type = r_type;
        n_id   = r_id;
        n_seq  = r_seq;
        n_rxck = r_rxck;
        n_sum  = r_sum;
        n_hbh  = r_hbh;
        limit  = ICMP_HDR_BYTES + POS_W'(i_payload_len);
        hl     = {((r_pos == '0) ? i_data_byte[3:0] : r_hw), 2'b00};
        rel    = r_pos - POS_W'(hl);
        v      = ((rel == ICMP_OFS_CK_HI) || (rel == ICMP_OFS_CK_LO)) ? 8'd0 : i_data_byte;
        if (r_pos < POS_W'(MAX_PACKET_BYTES)) begin
            if (r_pos == '0)          n_hw   = i_data_byte[3:0];
            if (r_pos == IP_OFS_TTL)   n_ttl  = i_data_byte;
            if (r_pos == IP_OFS_PROTO) n_icmp = (i_data_byte == PROTO_ICMP);
            if (r_pos >= POS_W'(hl)) begin
                if (rel == ICMP_OFS_TYPE)  n_type        = i_data_byte;
                if (rel == ICMP_OFS_CK_HI) n_rxck[15:8]  = i_data_byte;
                if (rel == ICMP_OFS_CK_LO) n_rxck[7:0]   = i_data_byte;
                if (rel == ICMP_OFS_ID_HI) n_id[15:8]    = i_data_byte;
                if (rel == ICMP_OFS_ID_LO) n_id[7:0]     = i_data_byte;
                if (rel == ICMP_OFS_SQ_HI) n_seq[15:8]   = i_data_byte;
                if (rel == ICMP_OFS_SQ_LO) n_seq[7:0]    = i_data_byte;
                if (rel < limit) begin
                    if (!rel[0]) begin
                        n_hbh = v;
                    end else begin
                        n_sum = fold_add(r_sum, {r_hbh, v});
                    end
                end
            end
            n_pos = r_pos + 1'b1;
        end
    end

    always_comb begin
        o_push           = i_accept && i_last;
        o_rec.byte_count = n_pos;
        o_rec.hdr_bytes  = {n_hw, 2'b00};
        o_rec.is_icmp    = n_icmp;
        o_rec.ttl        = n_ttl;
        o_rec.msg_type   = n_type;
        o_rec.ident      = n_id;
        o_rec.seq        = n_seq;
        o_rec.rx_cksum   = n_rxck;
        o_rec.sum        = n_sum;
        o_rec.high_byte  = n_hbh;
        o_rec.limit      = limit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_last)) begin
            r_pos  <= '0;
            r_hw   <= '0;
            r_icmp <= 1'b0;
            r_ttl  <= '0;
            r_type <= '0;
            r_id   <= '0;
            r_seq  <= '0;
            r_rxck <= '0;
            r_sum  <= '0;
            r_hbh  <= '0;
        end else if (i_accept) begin
            r_pos  <= n_pos;
            r_hw   <= n_hw;
            r_icmp <= n_icmp;
            r_ttl  <= n_ttl;
            r_type <= n_type;
            r_id   <= n_id;
            r_seq  <= n_seq;
            r_rxck <= n_rxck;
            r_sum  <= n_sum;
            r_hbh  <= n_hbh;
        end
    end

    `ERC_ASSERT_NXT(a_pos_clr, i_clk, i_rst_n, i_accept && i_last, r_pos == '0, "pos not cleared after last")
    `ERC_ASSERT_IMP(a_pos_max, i_clk, i_rst_n, 1'b1, r_pos <= POS_W'(MAX_PACKET_BYTES), "pos beyond max")

endmodule

@@ hw/rtl/icmp_erc_fifo.sv @@
// ============================================================================
// icmp_erc_fifo
// Short queue of packet summaries between parser and result stage.
// ============================================================================
`timescale 1ns / 1ps
`include "icmp_echo_reply_checker_defines.svh"

module icmp_erc_fifo (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  icmp_erc_pkg::t_pkt_rec i_rec,
    output logic                   o_full,
    output logic                   o_nonempty,
    input  logic                   i_pop,
    output icmp_erc_pkg::t_pkt_rec o_rec
);
    import icmp_erc_pkg::*;

    t_pkt_rec         r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full     = (r_count == CNT_W'(FIFO_DEPTH));
    assign o_nonempty = (r_count != '0);
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && o_nonempty;
    assign o_rec      = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (do_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `ERC_ASSERT_IMP(a_no_ovf, i_clk, i_rst_n, i_push, !o_full, "push into full queue")
    `ERC_ASSERT_NXT(a_cnt_up, i_clk, i_rst_n, do_push && !do_pop, r_count == CNT_W'($past(r_count) + 1'b1), "count did not rise")

endmodule

@@ hw/rtl/icmp_erc_back.sv @@
// ============================================================================
// icmp_erc_back
// Result stage: final checksum fold, match decision and output register.
// ============================================================================
`timescale 1ns / 1ps
`include "icmp_echo_reply_checker_defines.svh"

module icmp_erc_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_rec_valid,
    input  icmp_erc_pkg::t_pkt_rec          i_rec,
    output logic                            o_pop,
    input  logic [icmp_erc_pkg::WORD_W-1:0] i_expected_id,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_status,
    output icmp_erc_pkg::t_result           o_result
);
    import icmp_erc_pkg::*;

    logic              r_valid;
    logic              r_status, n_status;
    t_result           r_result, n_result;
    logic [POS_W-1:0]  icmp_len;
    logic [POS_W-1:0]  nsum;
    logic [SUM_W-1:0]  s;
    logic [WORD_W-1:0] comp;
    logic              valid;
    logic              match;

    assign o_pop = i_rec_valid && (!r_valid || i_ready);

    always_comb begin
        icmp_len = (i_rec.byte_count > POS_W'(i_rec.hdr_bytes))
                 ? i_rec.byte_count - POS_W'(i_rec.hdr_bytes) : '0;
        nsum     = (icmp_len < i_rec.limit) ? icmp_len : i_rec.limit;
        s        = nsum[0] ? fold_add(i_rec.sum, {i_rec.high_byte, 8'h00}) : i_rec.sum;
        comp     = ~s[WORD_W-1:0] & WORD_MASK;
        valid    = i_rec.is_icmp && (icmp_len >= ICMP_HDR_BYTES);
        match    = valid && (i_rec.msg_type == ICMP_ECHO_REPLY)
                && (i_rec.ident == i_expected_id);

        n_status                = !match;
        n_result                = '0;
        n_result.icmp_bytes     = icmp_len;
        n_result.msg_type       = valid ? i_rec.msg_type : 8'd0;
        n_result.type_valid     = valid;
        if (match) begin
            n_result.sequence_res   = i_rec.seq;
            n_result.ttl            = i_rec.ttl;
            n_result.computed_cksum = comp;
            n_result.received_cksum = i_rec.rx_cksum;
            n_result.ck_mismatch    = (comp != i_rec.rx_cksum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_status <= n_status;
            r_result <= n_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_status = r_status;
    assign o_result = r_result;

    `ERC_ASSERT_IMP(a_match_type, i_clk, i_rst_n, r_valid && !r_status, r_result.type_valid && (r_result.msg_type == ICMP_ECHO_REPLY), "match without echo reply header")
    `ERC_ASSERT_IMP(a_miss_zero, i_clk, i_rst_n, r_valid && r_status, (r_result.computed_cksum == '0) && !r_result.ck_mismatch, "mismatch carries checksum")

endmodule

@@ hw/rtl/icmp_echo_reply_checker.sv @@
// ============================================================================
// icmp_echo_reply_checker
// ICMP echo reply checker with ones-complement checksum over the message.
// ============================================================================
// Usage:
//   s_axis carries a received IPv4 packet, one byte per transaction, with
//   tlast on the final byte. One result leaves on m_axis per packet: tuser
//   holds the match status (0 match), tdata the lengths, fields and checksums.
//   The cfg channel writes expected_id (index 0) and payload_len (index 1);
//   o_cfg_ready is always high. Write only while no packet is in flight.
// Timing:
//   One byte per cycle is taken back to back while the queue is not full. A
//   packet's summary enters the two-entry queue when its last byte is taken,
//   then the result register, from which it is valid on m_axis.
//   Per-byte work is one 16-bit end-around-carry add in the parser.
// Reset:
//   i_rst_n clears the parser, the queue and the output valid; expected_id
//   returns to 0 and payload_len to 56.
// Stall:
//   While m_axis is stalled the result is held, the queue fills with up to
//   two more packet summaries, and s_axis_tready drops only when it is full.
// ============================================================================
`timescale 1ns / 1ps

module icmp_echo_reply_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // icmp_bytes, sequence_res, ttl, msg_type,
                                        // type_valid, computed_cksum, received_cksum,
                                        // ck_mismatch, zero pad
    output logic        m_axis_tuser,   // [0] status
    // configuration write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import icmp_erc_pkg::*;

    logic [WORD_W-1:0] r_expected_id;
    logic [PLEN_W-1:0] r_payload_len;
    logic              in_accept;
    logic              push;
    t_pkt_rec          push_rec;
    t_pkt_rec          pop_rec;
    logic              fifo_full;
    logic              fifo_nonempty;
    logic              pop;
    t_result           result;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !fifo_full;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_id <= '0;
            r_payload_len <= PAYLOAD_LEN_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_EXPECTED_ID: r_expected_id <= i_cfg_data;
                CFG_PAYLOAD_LEN: r_payload_len <= i_cfg_data[PLEN_W-1:0];
                default:         r_expected_id <= r_expected_id;
            endcase
        end
    end

    icmp_erc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_accept),
        .i_data_byte   (s_axis_tdata),
        .i_last        (s_axis_tlast),
        .i_payload_len (r_payload_len),
        .o_push        (push),
        .o_rec         (push_rec)
    );

    icmp_erc_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_rec      (push_rec),
        .o_full     (fifo_full),
        .o_nonempty (fifo_nonempty),
        .i_pop      (pop),
        .o_rec      (pop_rec)
    );

    icmp_erc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rec_valid   (fifo_nonempty),
        .i_rec         (pop_rec),
        .o_pop         (pop),
        .i_expected_id (r_expected_id),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_status      (m_axis_tuser),
        .o_result      (result)
    );

    assign m_axis_tdata = {2'b00, result.ck_mismatch, result.received_cksum,
                           result.computed_cksum, result.type_valid, result.msg_type,
                           result.ttl, result.sequence_res, result.icmp_bytes};

endmodule
